// File: rtl/u16u8_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
// No dependencies; used by u16u8_decode and utf16_to_utf8_transcoder.
`timescale 1ns / 1ps

package u16u8_pkg;

	// Status codes reported on the final result of a string
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_INVAL = 2'd1;
	localparam logic [1:0] STAT_NUL   = 2'd2;
	localparam logic [1:0] STAT_LIMIT = 2'd3;

	// Surrogate ranges
	localparam logic [15:0] HI_SURR_LO = 16'hD800;
	localparam logic [15:0] HI_SURR_HI = 16'hDBFF;
	localparam logic [15:0] LO_SURR_LO = 16'hDC00;
	localparam logic [15:0] LO_SURR_HI = 16'hDFFF;

	// Scalar ranges for the UTF-8 length
	localparam logic [20:0] SUPP_BASE  = 21'h10000;
	localparam logic [20:0] MAX_1BYTE  = 21'h0007F;
	localparam logic [20:0] MAX_2BYTE  = 21'h007FF;
	localparam logic [20:0] MAX_3BYTE  = 21'h0FFFF;

	localparam logic [16:0] UNITS_MAX  = 17'h1FFFF;
	localparam logic [15:0] LIMIT_RST  = 16'd4096;

	// Per-string state carried between code units
	typedef struct packed {
		logic        high_pending;
		logic [9:0]  high_bits;
		logic [16:0] bytes_emitted;
		logic [16:0] units_seen;
		logic [1:0]  first_error;
	} str_state_t;

	// Everything one code unit produces
	typedef struct packed {
		logic [3:0][7:0] bytes;     // bytes[0] goes out first
		logic [2:0]      count;     // results to send, 0..4
		logic            has_bytes; // results carry data bytes
		logic            done;      // final result closes the string
		logic [1:0]      status;
	} dec_result_t;

endpackage

// File: rtl/u16u8_decode.sv
// Combinational decode of one UTF-16 code unit against the string state.
// Joins surrogates, encodes UTF-8, tracks errors and limits. Uses u16u8_pkg.
`timescale 1ns / 1ps

module u16u8_decode (
	input  logic [15:0]             code_unit,
	input  logic                    string_start,
	input  logic                    string_last,
	input  logic [15:0]             byte_limit,
	input  u16u8_pkg::str_state_t   st,
	output u16u8_pkg::str_state_t   st_next,
	output u16u8_pkg::dec_result_t  res
);

	always_comb begin
		u16u8_pkg::str_state_t s;
		logic        have_scalar;
		logic [20:0] scalar;
		logic [2:0]  nbytes;
		logic [3:0][7:0] buf_b;
		logic [16:0] sum;

		s = st;
		have_scalar = 1'b0;
		scalar = '0;
		nbytes = 3'd0;
		buf_b = '0;
		sum = '0;

		// a start mark clears the string first
		if (string_start) begin
			s = '0;
		end

		if (s.units_seen < u16u8_pkg::UNITS_MAX) begin
			s.units_seen = s.units_seen + 17'd1;
		end

		// surrogate handling, only while the string is still clean
		if (s.first_error == u16u8_pkg::STAT_OK) begin
			if (s.high_pending) begin
				s.high_pending = 1'b0;
				if (code_unit inside {[u16u8_pkg::LO_SURR_LO:u16u8_pkg::LO_SURR_HI]}) begin
					scalar = {1'b0, s.high_bits, code_unit[9:0]} + u16u8_pkg::SUPP_BASE;
					have_scalar = 1'b1;
				end else begin
					s.first_error = u16u8_pkg::STAT_INVAL;
				end
				s.high_bits = '0;
			end else if (code_unit inside {[u16u8_pkg::HI_SURR_LO:u16u8_pkg::HI_SURR_HI]}) begin
				if (string_last) begin
					s.first_error = u16u8_pkg::STAT_INVAL;
				end else begin
					s.high_pending = 1'b1;
					s.high_bits = code_unit[9:0];
				end
			end else if (code_unit inside {[u16u8_pkg::LO_SURR_LO:u16u8_pkg::LO_SURR_HI]}) begin
				s.first_error = u16u8_pkg::STAT_INVAL;
			end else begin
				scalar = {5'd0, code_unit};
				have_scalar = 1'b1;
			end
		end

		// UTF-8 encode and output byte limit
		if (have_scalar) begin
			if (scalar == '0) begin
				s.first_error = u16u8_pkg::STAT_NUL;
			end else begin
				if (scalar <= u16u8_pkg::MAX_1BYTE) begin
					nbytes = 3'd1;
					buf_b[0] = scalar[7:0];
				end else if (scalar <= u16u8_pkg::MAX_2BYTE) begin
					nbytes = 3'd2;
					buf_b[0] = {3'b110, scalar[10:6]};
					buf_b[1] = {2'b10, scalar[5:0]};
				end else if (scalar <= u16u8_pkg::MAX_3BYTE) begin
					nbytes = 3'd3;
					buf_b[0] = {4'b1110, scalar[15:12]};
					buf_b[1] = {2'b10, scalar[11:6]};
					buf_b[2] = {2'b10, scalar[5:0]};
				end else begin
					nbytes = 3'd4;
					buf_b[0] = {5'b11110, scalar[20:18]};
					buf_b[1] = {2'b10, scalar[17:12]};
					buf_b[2] = {2'b10, scalar[11:6]};
					buf_b[3] = {2'b10, scalar[5:0]};
				end
				sum = s.bytes_emitted + {14'd0, nbytes};
				if (sum > {1'b0, byte_limit}) begin
					s.first_error = u16u8_pkg::STAT_LIMIT;
					nbytes = 3'd0;
				end
			end
		end

		// unit count over the limit overrides everything
		if (s.units_seen > {1'b0, byte_limit}) begin
			s.first_error = u16u8_pkg::STAT_LIMIT;
			nbytes = 3'd0;
		end

		s.bytes_emitted = s.bytes_emitted + {14'd0, nbytes};

		res.bytes     = buf_b;
		res.has_bytes = (nbytes != 3'd0);
		res.done      = string_last;
		res.status    = s.first_error;
		res.count     = (string_last && nbytes == 3'd0) ? 3'd1 : nbytes;

		st_next = string_last ? '0 : s;
	end

endmodule

// File: rtl/utf16_to_utf8_transcoder.sv
// Top level: UTF-16 code units in, UTF-8 bytes and string status out.
// Depends on u16u8_pkg and u16u8_decode.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------------
//   in      | in_valid/in_ready   | code_unit, string_start, string_last
//   out     | out_valid/out_ready | out_byte, byte_valid, run_last, string_done, status
//   cfg     | cfg_valid/cfg_ready | byte_limit
//
// A code unit waits in the input register, is decoded into the result register, and
// leaves as 1 to 4 results at one per cycle while out_ready is high; the result
// register's single output byte per cycle sets the rate. Units with no result skip
// the result register. The next unit is decoded in the cycle the last result of the
// previous one transfers. Reset clears the string state and sets byte_limit to 4096.
// Stalls on out_ready hold the result register and back up into in_ready.
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] code_unit,
	input  logic        string_start,
	input  logic        string_last,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        run_last,
	output logic        string_done,
	output logic [1:0]  status,
	// configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] byte_limit
);

	logic [15:0] limit_q;
	u16u8_pkg::str_state_t st_q, st_next;
	u16u8_pkg::dec_result_t dec_res;

	logic        v_s1;
	logic [15:0] unit_s1;
	logic        start_s1;
	logic        last_s1;

	logic        v_s2;
	u16u8_pkg::dec_result_t res_s2;
	logic [1:0]  idx_q;

	logic out_xfer;
	logic s2_free;
	logic advance;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= u16u8_pkg::LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= byte_limit;
		end
	end

	// handshake control
	assign out_xfer = v_s2 && out_ready;
	assign s2_free  = !v_s2 || (out_xfer && run_last);
	assign advance  = v_s1 && s2_free;
	assign in_ready = !v_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			unit_s1  <= code_unit;
			start_s1 <= string_start;
			last_s1  <= string_last;
		end
	end

	u16u8_decode u_decode (
		.code_unit    (unit_s1),
		.string_start (start_s1),
		.string_last  (last_s1),
		.byte_limit   (limit_q),
		.st           (st_q),
		.st_next      (st_next),
		.res          (dec_res)
	);

	// string state advances with each decoded unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	// result register and byte serializer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			idx_q <= '0;
		end else if (advance) begin
			v_s2  <= (dec_res.count != 3'd0);
			idx_q <= '0;
		end else if (out_xfer) begin
			if (run_last) begin
				v_s2 <= 1'b0;
			end
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= dec_res;
		end
	end

	// output fields
	assign out_valid   = v_s2;
	assign byte_valid  = res_s2.has_bytes;
	assign out_byte    = res_s2.has_bytes ? res_s2.bytes[idx_q] : 8'd0;
	assign run_last    = ({1'b0, idx_q} == (res_s2.count - 3'd1));
	assign string_done = res_s2.done && run_last;
	assign status      = string_done ? res_s2.status : u16u8_pkg::STAT_OK;

	// checks
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> ({1'b0, idx_q} < res_s2.count))
		else $error("serializer index past byte count");

	a_status_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !byte_valid) |-> (string_done && run_last))
		else $error("status-only result that does not close a string");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (st_q.units_seen == '0 && st_q.first_error == '0))
		else $error("string state not cleared after last unit");

	a_bytes_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.bytes_emitted[16] == 1'b0)
		else $error("byte count beyond any limit");

endmodule

// File: test/tb.sv
// Self-checking testbench for utf16_to_utf8_transcoder: directed and random UTF-16 strings.
// Depends on u16u8_pkg and the transcoder RTL; a scoreboard class predicts each UTF-8 result.
`timescale 1ns / 1ps

module tb;

	// One expected result on the output channel
	typedef struct {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       run_last;
		logic       string_done;
		logic [1:0] status;
	} utf8_result_t;

	// Predicts the byte stream and string status, holds results still to come
	class utf8_scoreboard;
		logic [15:0]  limit;
		logic         high_pending;
		logic [9:0]   high_bits;
		logic [16:0]  bytes_emitted;
		logic [16:0]  units_seen;
		logic [1:0]   first_error;
		utf8_result_t due[$];
		int           fails;
		int           checked;

		function new();
			limit = u16u8_pkg::LIMIT_RST;
			fails = 0;
			checked = 0;
			reset_string();
		endfunction

		function void reset_string();
			high_pending = 1'b0;
			high_bits = '0;
			bytes_emitted = '0;
			units_seen = '0;
			first_error = u16u8_pkg::STAT_OK;
		endfunction

		function void flag(logic [1:0] code);
			if (first_error == u16u8_pkg::STAT_OK)
				first_error = code;
		endfunction

		function void set_limit(logic [15:0] value);
			limit = value;
		endfunction

		function int pending();
			return due.size();
		endfunction

		// Decode one accepted code unit and queue the results it causes
		function void note_unit(logic [15:0] unit, logic start, logic last);
			logic [20:0]  scalar;
			bit           have_scalar;
			int           nbytes;
			int           n;
			logic [7:0]   enc [4];
			utf8_result_t res [4];

			if (start)
				reset_string();
			if (units_seen < u16u8_pkg::UNITS_MAX)
				units_seen++;
			nbytes = 0;
			have_scalar = 0;
			scalar = '0;

			if (first_error == u16u8_pkg::STAT_OK) begin
				if (high_pending) begin
					// unit after a held high surrogate is consumed either way
					high_pending = 1'b0;
					if (unit >= u16u8_pkg::LO_SURR_LO && unit <= u16u8_pkg::LO_SURR_HI) begin
						scalar = u16u8_pkg::SUPP_BASE + {high_bits, 10'b0}
							+ (unit - u16u8_pkg::LO_SURR_LO);
						have_scalar = 1;
					end else
						flag(u16u8_pkg::STAT_INVAL);
					high_bits = '0;
				end else if (unit >= u16u8_pkg::HI_SURR_LO && unit <= u16u8_pkg::HI_SURR_HI) begin
					if (last)
						flag(u16u8_pkg::STAT_INVAL);
					else begin
						high_pending = 1'b1;
						high_bits = unit[9:0];
					end
				end else if (unit >= u16u8_pkg::LO_SURR_LO && unit <= u16u8_pkg::LO_SURR_HI)
					flag(u16u8_pkg::STAT_INVAL);
				else begin
					scalar = {5'b0, unit};
					have_scalar = 1;
				end

				if (have_scalar) begin
					if (scalar == 0)
						flag(u16u8_pkg::STAT_NUL);
					else begin
						if (scalar <= u16u8_pkg::MAX_1BYTE) begin
							enc[0] = scalar[7:0];
							nbytes = 1;
						end else if (scalar <= u16u8_pkg::MAX_2BYTE) begin
							enc[0] = {3'b110, scalar[10:6]};
							enc[1] = {2'b10, scalar[5:0]};
							nbytes = 2;
						end else if (scalar <= u16u8_pkg::MAX_3BYTE) begin
							enc[0] = {4'b1110, scalar[15:12]};
							enc[1] = {2'b10, scalar[11:6]};
							enc[2] = {2'b10, scalar[5:0]};
							nbytes = 3;
						end else begin
							enc[0] = {5'b11110, scalar[20:18]};
							enc[1] = {2'b10, scalar[17:12]};
							enc[2] = {2'b10, scalar[11:6]};
							enc[3] = {2'b10, scalar[5:0]};
							nbytes = 4;
						end
						if (int'(bytes_emitted) + nbytes > int'(limit)) begin
							flag(u16u8_pkg::STAT_LIMIT);
							nbytes = 0;
						end
					end
				end
			end

			// unit count over the limit overrides every other error
			if (units_seen > {1'b0, limit}) begin
				first_error = u16u8_pkg::STAT_LIMIT;
				nbytes = 0;
			end
			bytes_emitted += nbytes[16:0];

			n = 0;
			for (int k = 0; k < nbytes; k++) begin
				res[n] = '{enc[k], 1'b1, 1'b0, 1'b0, u16u8_pkg::STAT_OK};
				n++;
			end
			if (last) begin
				if (n == 0) begin
					res[0] = '{8'h00, 1'b0, 1'b0, 1'b0, u16u8_pkg::STAT_OK};
					n = 1;
				end
				res[n-1].string_done = 1'b1;
				res[n-1].status = first_error;
				reset_string();
			end
			if (n > 0)
				res[n-1].run_last = 1'b1;
			for (int k = 0; k < n; k++)
				due.push_back(res[k]);
		endfunction

		// Compare one transferred result with the oldest expectation
		function void check_result(logic [7:0] ob, logic bv, logic rl, logic sd, logic [1:0] st);
			utf8_result_t e;

			if (due.size() == 0) begin
				$error("unexpected result: out_byte %h byte_valid %b", ob, bv);
				fails++;
				return;
			end
			e = due.pop_front();
			checked++;
			if (ob !== e.data_byte) begin
				$error("out_byte: expected %h, got %h", e.data_byte, ob);
				fails++;
			end
			if (bv !== e.byte_valid) begin
				$error("byte_valid: expected %b, got %b", e.byte_valid, bv);
				fails++;
			end
			if (rl !== e.run_last) begin
				$error("run_last: expected %b, got %b", e.run_last, rl);
				fails++;
			end
			if (sd !== e.string_done) begin
				$error("string_done: expected %b, got %b", e.string_done, sd);
				fails++;
			end
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				fails++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] code_unit = '0;
	logic        string_start = 1'b0;
	logic        string_last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        run_last;
	logic        string_done;
	logic [1:0]  status;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] byte_limit = '0;

	utf8_scoreboard sb = new();
	bit in_burst = 0;
	bit out_burst = 0;
	int units_sent = 0;
	int limit_writes = 0;

	utf16_to_utf8_transcoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.code_unit    (code_unit),
		.string_start (string_start),
		.string_last  (string_last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.run_last     (run_last),
		.string_done  (string_done),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.byte_limit   (byte_limit)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Transfer monitor: input side first, so its results are queued before any check
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_unit(code_unit, string_start, string_last);
			if (out_valid && out_ready)
				sb.check_result(out_byte, byte_valid, run_last, string_done, status);
		end
	end

	// Result sink with random back-pressure
	initial begin
		int stall;

		@(posedge clk);
		forever begin
			if ($urandom_range(0, 19) == 0)
				out_burst = !out_burst;
			stall = out_burst ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Present one code unit; returns at the edge of its transfer
	task automatic send_unit(logic [15:0] unit, logic start, logic last);
		int gap;

		if ($urandom_range(0, 19) == 0)
			in_burst = !in_burst;
		gap = in_burst ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		code_unit <= unit;
		string_start <= start;
		string_last <= last;
		do @(posedge clk); while (!in_ready);
		units_sent++;
	endtask

	// Let the block go idle: all results in, then a wait for unit-only work
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(logic [15:0] value);
		cfg_valid <= 1'b1;
		byte_limit <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_limit(value);
		limit_writes++;
	endtask

	// One random string; clean strings hold only well-formed scalars
	task automatic send_string(int len, bit clean);
		logic [15:0] units[$];
		int          kind;
		bit          mark;
		logic        st;

		while (units.size() < len) begin
			kind = $urandom_range(0, 9);
			if (!clean && $urandom_range(0, 3) == 0)
				kind = 10 + $urandom_range(0, 3);
			case (kind)
				0, 1, 2: units.push_back(16'($urandom_range(1, 16'h7F)));
				3, 4:    units.push_back(16'($urandom_range(16'h80, 16'h7FF)));
				5, 6: begin
					if ($urandom_range(0, 1))
						units.push_back(16'($urandom_range(16'h800, 16'hD7FF)));
					else
						units.push_back(16'($urandom_range(16'hE000, 16'hFFFF)));
				end
				7, 8, 9: begin
					if (units.size() + 2 <= len) begin
						units.push_back(u16u8_pkg::HI_SURR_LO + 16'($urandom_range(0, 1023)));
						units.push_back(u16u8_pkg::LO_SURR_LO + 16'($urandom_range(0, 1023)));
					end else
						units.push_back(16'($urandom_range(1, 16'h7F)));
				end
				10: units.push_back(16'($urandom_range(0, 16'hFFFF)));
				11: units.push_back(u16u8_pkg::LO_SURR_LO + 16'($urandom_range(0, 1023)));
				12: units.push_back(u16u8_pkg::HI_SURR_LO + 16'($urandom_range(0, 1023)));
				default: units.push_back(16'h0000);
			endcase
		end
		mark = ($urandom_range(0, 7) != 0);
		foreach (units[i]) begin
			// a stray start mark restarts the string mid-way
			st = (i == 0 && mark) || (!clean && $urandom_range(0, 15) == 0);
			send_unit(units[i], st, i == units.size() - 1);
		end
	endtask

	// Main sequence
	initial begin
		logic [15:0] limits [11];
		int          target;
		int          len;

		limits = '{16'd65535, 16'd0, 16'd2, 16'd5, 16'd9, 16'd17, 16'd40,
			16'd65535, 16'd1, 16'd4096, 16'd12};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every UTF-8 length at its range edges, then both pair extremes
		send_unit(16'h0041, 1, 0);
		send_unit(16'h007F, 0, 0);
		send_unit(16'h0080, 0, 0);
		send_unit(16'h07FF, 0, 0);
		send_unit(16'h0800, 0, 0);
		send_unit(16'hFFFF, 0, 0);
		send_unit(16'hD800, 0, 0);
		send_unit(16'hDC00, 0, 0);
		send_unit(16'hDBFF, 0, 0);
		send_unit(16'hDFFF, 0, 1);
		// lone low surrogate
		send_unit(16'hDC00, 1, 0);
		send_unit(16'h0041, 0, 1);
		// high surrogate followed by a non-surrogate, no start mark
		send_unit(16'hD800, 0, 0);
		send_unit(16'h0041, 0, 1);
		// truncated pair on a single-unit string
		send_unit(16'hDBFF, 1, 1);
		// NUL scalar
		send_unit(16'h0000, 1, 1);
		// high followed by high
		send_unit(16'h0041, 1, 0);
		send_unit(16'hD801, 0, 0);
		send_unit(16'hD802, 0, 1);
		// limit lowered in the middle of a string: byte limit hit
		send_unit(16'h0061, 1, 0);
		send_unit(16'h0062, 0, 0);
		drain();
		write_limit(16'd4);
		send_unit(16'h20AC, 0, 0);
		send_unit(16'h0063, 0, 1);
		// unit count over the limit overrides an earlier NUL error
		send_unit(16'h0000, 1, 0);
		send_unit(16'h0041, 0, 0);
		send_unit(16'h0041, 0, 0);
		send_unit(16'h0041, 0, 0);
		send_unit(16'h0041, 0, 1);

		// Random strings under a series of limits, extremes included
		foreach (limits[p]) begin
			drain();
			write_limit(limits[p]);
			target = units_sent + 27;
			while (units_sent < target) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
				send_string(len, $urandom_range(0, 3) != 0);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		$display("tb: %0d code units sent, %0d results checked, %0d byte_limit writes",
			units_sent, sb.checked, limit_writes);
		if (sb.fails == 0 && sb.pending() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// Watchdog
	initial begin
		#400000;
		$display("tb: timeout with %0d results outstanding", sb.pending());
		$display("tb NOT OK");
		$finish;
	end

endmodule
